[sv/aob_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alpha-over blend package
// Shared types and constants for the source-over compositing pipeline.
// ----------------------------------------------------------------------------
package aob_pkg;

   localparam int unsigned DEN      = 65280;
   localparam int unsigned DEN_SQ   = 32'd4261478400;
   localparam int unsigned NA_LIMIT = 4261478;
   localparam int unsigned ALPHA_DEN = 16711680;
   localparam int unsigned OPAQUE   = 256;
   localparam int unsigned LANES    = 4;
   localparam int unsigned QBITS    = 8;

   typedef struct packed {
      logic [39:0] rem;
      logic [31:0] den;
      logic [7:0]  quo;
      logic        sat;
   } lane_type;

   typedef struct packed {
      lane_type [LANES-1:0] lane;
      logic [31:0]          dst;
      logic                 pass;
   } item_type;

endpackage

[sv/aob_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alpha-over blend front end
// Four registered stages that form the blend numerators and output alpha.
// ----------------------------------------------------------------------------
module aob_front (
   input  logic                clock,
   input  logic                reset,
   input  logic [8:0]          opacity,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [63:0]         in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output aob_pkg::item_type   out_item
);
   import aob_pkg::*;

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic r1, r2, r3, r4;
   logic [8:0]  op;
   logic [15:0] sa_ff, da_ff, inv_ff;
   logic [23:0] sc_ff, dc_ff;
   logic [31:0] dst1_ff, dst2_ff, dst3_ff;
   logic [31:0] psa_ff, pda_ff, na_ff;
   logic [2:0][23:0] cs_ff, cd_ff;
   logic [2:0][39:0] ns_ff, nd_ff;
   logic [15:0] sa_in;
   item_type    item_ff, item_in;

   assign r4 = !v4_ff || out_ready;
   assign r3 = !v3_ff || r4;
   assign r2 = !v2_ff || r3;
   assign r1 = !v1_ff || r2;
   assign in_ready  = r1;
   assign out_valid = v4_ff;
   assign out_item  = item_ff;

   assign op    = opacity[8] ? 9'(OPAQUE) : opacity;
   assign sa_in = 16'(in_data[31:24] * op);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (r1) v1_ff <= in_valid;
         if (r2) v2_ff <= v1_ff;
         if (r3) v3_ff <= v2_ff;
         if (r4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (r1) begin
         sa_ff   <= sa_in;
         da_ff   <= {in_data[63:56], 8'd0};
         sc_ff   <= in_data[23:0];
         dc_ff   <= in_data[55:32];
         dst1_ff <= in_data[63:32];
      end
      if (r2) begin
         inv_ff  <= 16'(DEN) - sa_ff;
         psa_ff  <= sa_ff * 16'(DEN);
         pda_ff  <= da_ff * (16'(DEN) - sa_ff);
         dst2_ff <= dst1_ff;
         for (int i = 0; i < 3; i++) begin
            cs_ff[i] <= sc_ff[8*i +: 8] * sa_ff;
            cd_ff[i] <= dc_ff[8*i +: 8] * da_ff;
         end
      end
      if (r3) begin
         na_ff   <= psa_ff + pda_ff;
         dst3_ff <= dst2_ff;
         for (int i = 0; i < 3; i++) begin
            ns_ff[i] <= cs_ff[i] * 16'(DEN);
            nd_ff[i] <= cd_ff[i] * inv_ff;
         end
      end
      if (r4) begin
         item_ff <= item_in;
      end
   end

   // Output alpha is na / (255 * 65536); the division by 255 of the upper half
   // is done by the add-and-shift identity, so that lane leaves the cells untouched.
   always_comb begin
      logic [39:0] num;
      logic [15:0] asum;
      item_in.dst  = dst3_ff;
      item_in.pass = na_ff <= 32'(NA_LIMIT);
      for (int i = 0; i < 3; i++) begin
         num = ns_ff[i] + nd_ff[i];
         item_in.lane[i].rem = num;
         item_in.lane[i].den = na_ff;
         item_in.lane[i].quo = '0;
         item_in.lane[i].sat = num >= {na_ff, 8'd0};
      end
      asum = na_ff[31:16] + {8'd0, na_ff[31:24]} + 16'd1;
      item_in.lane[3].rem = '0;
      item_in.lane[3].den = 32'(ALPHA_DEN);
      item_in.lane[3].quo = asum[15:8];
      item_in.lane[3].sat = 1'b0;
   end

endmodule

[sv/aob_div_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alpha-over blend divider cell
// Resolves one quotient bit for every lane by restoring division.
// ----------------------------------------------------------------------------
module aob_div_cell #(
   parameter int unsigned BIT = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  aob_pkg::item_type in_item,
   output logic              out_valid,
   input  logic              out_ready,
   output aob_pkg::item_type out_item
);
   import aob_pkg::*;

   logic     valid_ff;
   item_type item_ff, item_in;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_comb begin
      logic [39:0] step;
      item_in = in_item;
      for (int i = 0; i < LANES; i++) begin
         step = 40'(in_item.lane[i].den) << BIT;
         if (!in_item.lane[i].sat && in_item.lane[i].rem >= step) begin
            item_in.lane[i].rem      = in_item.lane[i].rem - step;
            item_in.lane[i].quo[BIT] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         item_ff <= item_in;
      end
   end

endmodule

[sv/alpha_over_blend_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alpha-over blend unit
// Source-over compositing of RGBA pixels with a global opacity register.
// ----------------------------------------------------------------------------
// Pipeline: 4 arithmetic stages, 8 divider cells and 1 output register. Throughput:
// one pixel per cycle while the result channel does not stall, set by the chain
// of one-bit divider cells that each pixel walks through.
// Reset clears all stage valid flags and loads opacity with 256.
module alpha_over_blend_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // src_red, src_green, src_blue, src_alpha, dst_red, dst_green, dst_blue, dst_alpha
   input  logic [63:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // out_red, out_green, out_blue, out_alpha
   output logic [31:0] rsp_tdata,
   // written
   output logic        rsp_tuser,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [8:0]  csr_data
);
   import aob_pkg::*;

   logic [8:0] opacity_ff;
   logic       rsp_valid_ff;
   logic [31:0] rsp_data_ff, rsp_data_in;
   logic       rsp_user_ff;
   logic       out_ready;

   logic     [QBITS:0] cv, cr;
   item_type [QBITS:0] ci;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         opacity_ff <= 9'(OPAQUE);
      end else if (csr_valid) begin
         opacity_ff <= csr_data;
      end
   end

   aob_front u_front (
      .clock     (clock),
      .reset     (reset),
      .opacity   (opacity_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (req_tdata),
      .out_valid (cv[0]),
      .out_ready (cr[0]),
      .out_item  (ci[0])
   );

   for (genvar k = 0; k < QBITS; k++) begin : g_cell
      aob_div_cell #(.BIT(QBITS - 1 - k)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (cv[k]),
         .in_ready  (cr[k]),
         .in_item   (ci[k]),
         .out_valid (cv[k+1]),
         .out_ready (cr[k+1]),
         .out_item  (ci[k+1])
      );
   end

   assign out_ready     = !rsp_valid_ff || rsp_tready;
   assign cr[QBITS]     = out_ready;

   always_comb begin
      if (ci[QBITS].pass) begin
         rsp_data_in = ci[QBITS].dst;
      end else begin
         for (int i = 0; i < LANES; i++) begin
            rsp_data_in[8*i +: 8] = ci[QBITS].lane[i].sat ? 8'hFF : ci[QBITS].lane[i].quo;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= cv[QBITS];
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= !ci[QBITS].pass;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");
   a_drain_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled while output register empty");
   a_opacity: assert property (@(posedge clock) disable iff (reset)
      !csr_valid |=> $stable(opacity_ff))
      else $error("opacity changed without a write");

endmodule

[tb/sv/alpha_over_blend_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alpha-over blend checker
// Watches the opacity, pixel and result channels of the blend unit, predicts
// each blended pixel with exact rational arithmetic and compares it, in order,
// with the pixel that the unit returns.
// ----------------------------------------------------------------------------
module alpha_over_blend_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   input  logic        rsp_tuser,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [8:0]  csr_data,
   output int          fail_count,
   output int          pending_count,
   output int          blended_count,
   output int          passed_count
);

   typedef struct packed {
      logic        written;
      logic [31:0] rgba;
   } pixel_type;

   logic [8:0] opacity_q;
   pixel_type  pending_pixels[$];

   function automatic logic [7:0] clamp_div(logic [63:0] num, logic [63:0] den);
      logic [63:0] q;
      begin
         q = num / den;
         clamp_div = (q > 64'd255) ? 8'd255 : q[7:0];
      end
   endfunction

   function automatic pixel_type blend_pixel(logic [63:0] px, logic [8:0] opac);
      logic [63:0] d, op, sa_n, da_n, inv_sa, na, dd, num;
      pixel_type   r;
      int          i;
      begin
         d = 64'd65280;
         op = (opac > 9'd256) ? 64'd256 : {55'd0, opac};
         sa_n = px[31:24] * op;
         da_n = px[63:56] * 64'd256;
         inv_sa = d - sa_n;
         dd = d * d;
         na = sa_n * d + da_n * inv_sa;
         if (na * 64'd1000 <= dd) begin
            r.rgba = px[63:32];
            r.written = 1'b0;
         end else begin
            for (i = 0; i < 3; i++) begin
               num = px[8*i +: 8] * sa_n * d + px[32 + 8*i +: 8] * da_n * inv_sa;
               r.rgba[8*i +: 8] = clamp_div(num, na);
            end
            r.rgba[31:24] = clamp_div(na * 64'd255, dd);
            r.written = 1'b1;
         end
         blend_pixel = r;
      end
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      begin
         $display("MISMATCH at %0t: %s got %h want %h", $realtime, what, got, want);
         fail_count++;
      end
   endtask

   initial begin
      fail_count = 0;
      blended_count = 0;
      passed_count = 0;
   end

   assign pending_count = pending_pixels.size();

   always @(posedge clock) begin
      pixel_type want;
      if (reset) begin
         opacity_q <= 9'd256;
      end else begin
         if (csr_valid && csr_ready) begin
            opacity_q <= csr_data;
         end
         if (req_tvalid && req_tready) begin
            pending_pixels = {pending_pixels, blend_pixel(req_tdata, opacity_q)};
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_pixels.size() == 0) begin
               report_mismatch("unexpected result", rsp_tdata, 32'd0);
            end else begin
               want = pending_pixels.pop_front();
               if (want.written) blended_count++;
               else passed_count++;
               if (rsp_tdata[7:0] !== want.rgba[7:0])
                  report_mismatch("red", {24'd0, rsp_tdata[7:0]},
                                  {24'd0, want.rgba[7:0]});
               if (rsp_tdata[15:8] !== want.rgba[15:8])
                  report_mismatch("green", {24'd0, rsp_tdata[15:8]},
                                  {24'd0, want.rgba[15:8]});
               if (rsp_tdata[23:16] !== want.rgba[23:16])
                  report_mismatch("blue", {24'd0, rsp_tdata[23:16]},
                                  {24'd0, want.rgba[23:16]});
               if (rsp_tdata[31:24] !== want.rgba[31:24])
                  report_mismatch("alpha", {24'd0, rsp_tdata[31:24]},
                                  {24'd0, want.rgba[31:24]});
               if (rsp_tuser !== want.written)
                  report_mismatch("written", {31'd0, rsp_tuser}, {31'd0, want.written});
            end
         end
      end
   end

endmodule

[tb/sv/alpha_over_blend_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alpha-over blend unit testbench
// Drives directed and random pixels through the blend unit under several
// opacity settings, with random gaps and stalls on both channels, and leaves
// the checking to the companion checker.
// ----------------------------------------------------------------------------
module alpha_over_blend_unit_tb;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_valid;
   logic        csr_ready;
   logic [8:0]  csr_data;
   int          fail_count, pending_count, blended_count, passed_count;
   int          cycle_count;
   int          sent_count;
   bit          calm_mode;
   bit          hold_rsp;

   alpha_over_blend_unit uut (.*);

   alpha_over_blend_checker checker_inst (.*);

   initial clock = 1'b0;
   always #10 clock = ~clock;

   initial begin
      req_tvalid = 1'b0;
      req_tdata = 64'd0;
      csr_valid = 1'b0;
      csr_data = 9'd256;
      rsp_tready = 1'b0;
      reset = 1'b1;
      calm_mode = 1'b0;
      hold_rsp = 1'b0;
      sent_count = 0;
      cycle_count = 0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("Timeout waiting for results");
         $display("Mismatches found");
         $finish;
      end
   end

   // Receiver: random stall bursts, off during the calm part and while held.
   initial begin
      int n;
      @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            @(posedge clock);
         end else if (!calm_mode && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 8);
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   // Long receiver hold-off, counted in its own process.
   initial begin
      wait (sent_count > 100);
      @(posedge clock);
      hold_rsp = 1'b1;
      repeat (60) @(posedge clock);
      hold_rsp = 1'b0;
   end

   task automatic send_pixel(logic [63:0] px);
      begin
         if (!calm_mode && $urandom_range(0, 4) == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata <= px;
         @(posedge clock);
         while (!req_tready) @(posedge clock);
         sent_count++;
      end
   endtask

   task automatic idle_req;
      begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic write_opacity(logic [8:0] value);
      begin
         while (pending_count != 0) @(posedge clock);
         repeat (16) @(posedge clock);
         csr_valid <= 1'b1;
         csr_data <= value;
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         csr_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   function automatic logic [63:0] random_pixel();
      logic [63:0] px;
      begin
         px = {$urandom, $urandom};
         case ($urandom_range(0, 7))
            0: px[31:24] = 8'd0;
            1: px[31:24] = 8'd255;
            2: px[63:56] = 8'd0;
            3: px[63:56] = 8'd255;
            4: begin
               px[31:24] = $urandom_range(0, 3);
               px[63:56] = $urandom_range(0, 3);
            end
            default: ;
         endcase
         random_pixel = px;
      end
   endfunction

   initial begin
      logic [8:0] settings[8];
      int k, j;
      settings = '{9'd256, 9'd0, 9'd1, 9'd128, 9'd255, 9'd257, 9'd511, 9'd200};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed pixels at the reset opacity.
      send_pixel(64'h0);
      send_pixel({64{1'b1}});
      send_pixel({32'hFFFFFFFF, 32'h00FFFFFF});
      send_pixel({32'h00FFFFFF, 32'hFF000000});
      send_pixel({32'h01804020, 32'h00102030});
      send_pixel({32'h04AABBCC, 32'h00112233});
      send_pixel({32'h80123456, 32'h80FEDCBA});
      send_pixel({32'hFF00FF00, 32'h01FF00FF});
      send_pixel({32'h00000000, 32'h01000000});
      send_pixel({32'h7F7F7F7F, 32'h7F7F7F7F});
      idle_req();
      write_opacity(9'd0);
      send_pixel({32'h01FFFFFF, 32'hFFFFFFFF});
      send_pixel({32'hFF123456, 32'hFF654321});
      send_pixel({32'h00ABCDEF, 32'hFF000000});
      idle_req();
      write_opacity(9'd1);
      send_pixel({32'h00FFFFFF, 32'hFFFFFFFF});
      send_pixel({32'h00000000, 32'h04FFFFFF});
      send_pixel({32'h01000000, 32'hFFFFFFFF});
      idle_req();
      write_opacity(9'd511);
      send_pixel({32'h40102030, 32'hC0A0B0C0});
      send_pixel({32'h00000000, 32'hFFFFFFFF});

      for (k = 0; k < 8; k++) begin
         idle_req();
         write_opacity(settings[k]);
         if (k == 7) calm_mode = 1'b1;
         for (j = 0; j < 150; j++) send_pixel(random_pixel());
      end
      idle_req();

      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("Sent %0d pixels over eight opacity settings including 0, 1, 256 and 511.",
               sent_count);
      $display("Results seen: %0d blended, %0d passed through.", blended_count,
               passed_count);
      if (fail_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
